@@ rtl/byte_ring_fifo_le_reader_macros.svh @@
// Assertion macros for the checker file of the byte ring FIFO reader.
// Each macro expects clk and arst_n in scope.
`ifndef BYTE_RING_FIFO_LE_READER_MACROS_SVH
`define BYTE_RING_FIFO_LE_READER_MACROS_SVH

// same-cycle implication
`define BRFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brfr assertion failed");

// next-cycle implication
`define BRFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brfr assertion failed");

`endif

@@ rtl/brfr_pkg.sv @@
// Types and constants for the byte ring FIFO reader.
// No dependencies.
package brfr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FETCH,
		ST_DRAIN,
		ST_COMMIT,
		ST_OUT
	} brfr_state_t;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_READ  = 2'd1,
		FN_PEEK  = 2'd2,
		FN_SKIP  = 2'd3
	} brfr_func_t;

	localparam int unsigned MAX_WORD_BYTES = 4;
	localparam int unsigned COUNT_W        = 12;

endpackage

@@ rtl/brfr_wrap_add.sv @@
// Shared pointer adder: (a + b) modulo DEPTH, with a and b below DEPTH.
// Standalone; used by the top level for every pointer and address step.
module brfr_wrap_add #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned PW    = 12
) (
	input  logic [PW-1:0] a,
	input  logic [PW-1:0] b,
	output logic [PW-1:0] sum
);
	logic [PW:0] raw;

	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		if (raw >= (PW+1)'(DEPTH)) begin
			raw = raw - (PW+1)'(DEPTH);
		end
		sum = raw[PW-1:0];
	end
endmodule

@@ rtl/brfr_mem.sv @@
// Byte store: one write port, one read port with registered read data.
// Standalone; contents are not cleared by reset.
module brfr_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned PW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [PW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [PW-1:0] raddr,
	output logic [7:0]    rdata_q
);
	logic [7:0] store [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
		rdata_q <= store[raddr];
	end
endmodule

@@ rtl/byte_ring_fifo_le_reader.sv @@
// Byte ring FIFO with little-endian word reader: top level with sequencer.
// Depends on brfr_pkg, brfr_mem, brfr_wrap_add.
//
// Usage:
//   An item (func, write_byte, amount) is taken at a clock edge with start
//   high and busy low. busy stays high until the result has been shown.
//   The result appears on the result ports for exactly one cycle with valid
//   high; the receiver cannot stall and must take it then.
//   Each item runs through the states EVAL and OUT; a read or peek of n
//   bytes that passes its checks runs FETCH once per byte and then DRAIN
//   in between, and a read adds COMMIT before OUT. busy falls after OUT,
//   and only then can a new item be taken, so items never overlap.
//   The pace is set by the byte store's single read port, one byte per
//   cycle, and by the one shared wrap-around pointer adder.
//   Reset (arst_n low) empties the FIFO and clears both running totals;
//   the byte store itself is not swept, no clearing pass is needed.
module byte_ring_fifo_le_reader #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  write_byte,
	input  logic [11:0] amount,
	output logic        valid,
	output logic [31:0] value,
	output logic        ok,
	output logic [11:0] done_count,
	output logic [11:0] stored_count,
	output logic [11:0] free_count,
	output logic [31:0] total_read,
	output logic [31:0] total_written
);
	import brfr_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = (PW > COUNT_W) ? PW : COUNT_W;

	brfr_state_t state_q, state_d;

	brfr_func_t    func_q;
	logic [7:0]    wbyte_q;
	logic [11:0]   amt_q;
	logic [PW-1:0] rp_q, wp_q, cnt_q, addr_q;
	logic [31:0]   cons_q, acc_q;
	logic [2:0]    k_q;
	logic [1:0]    lane_q;
	logic          pend_q;
	logic [31:0]   word_q;
	logic          ok_q;
	logic [11:0]   done_q;

	logic          mem_we;
	logic [PW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic [PW-1:0] ua, ub, usum;

	logic          wr_ok, rd_ok, last_issue;
	logic [PW-1:0] skip_n, amt_pw, free_pw;
	logic [CW-1:0] cnt_ext, free_ext, skip_ext;

	assign amt_pw     = PW'(amt_q);
	assign cnt_ext    = CW'(cnt_q);
	assign wr_ok      = cnt_q < PW'(DEPTH - 1);
	assign rd_ok      = (amt_q != 12'd0) && (amt_q <= 12'(MAX_WORD_BYTES))
	                    && (CW'(amt_q) <= cnt_ext);
	assign skip_n     = (CW'(amt_q) > cnt_ext) ? cnt_q : amt_pw;
	assign skip_ext   = CW'(skip_n);
	assign last_issue = k_q == (amt_q[2:0] - 3'd1);
	assign free_pw    = PW'(DEPTH - 1) - cnt_q;
	assign free_ext   = CW'(free_pw);

	brfr_mem #(.DEPTH(DEPTH), .PW(PW)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (wp_q),
		.wdata   (wbyte_q),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	brfr_wrap_add #(.DEPTH(DEPTH), .PW(PW)) u_add (
		.a   (ua),
		.b   (ub),
		.sum (usum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_raddr = addr_q;
		ua        = rp_q;
		ub        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				case (func_q)
					FN_WRITE: begin
						mem_we  = wr_ok;
						ua      = wp_q;
						ub      = PW'(1);
						state_d = ST_OUT;
					end
					FN_READ, FN_PEEK: begin
						state_d = rd_ok ? ST_FETCH : ST_OUT;
					end
					FN_SKIP: begin
						ub      = skip_n;
						state_d = ST_OUT;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_FETCH: begin
				ua = addr_q;
				ub = PW'(1);
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = (func_q == FN_READ) ? ST_COMMIT : ST_OUT;
			end
			ST_COMMIT: begin
				ub      = amt_pw;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pointers, counts and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			cnt_q  <= '0;
			cons_q <= '0;
			acc_q  <= '0;
			k_q    <= '0;
			pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_EVAL: begin
					k_q    <= '0;
					pend_q <= 1'b0;
					if (func_q == FN_WRITE && wr_ok) begin
						wp_q  <= usum;
						cnt_q <= cnt_q + PW'(1);
						acc_q <= acc_q + 32'd1;
					end
					if (func_q == FN_SKIP && amt_q != 12'd0) begin
						rp_q   <= usum;
						cnt_q  <= cnt_q - skip_n;
						cons_q <= cons_q + 32'(skip_n);
					end
				end
				ST_FETCH: begin
					k_q    <= k_q + 3'd1;
					pend_q <= 1'b1;
				end
				ST_COMMIT: begin
					rp_q   <= usum;
					cnt_q  <= cnt_q - amt_pw;
					cons_q <= cons_q + 32'(amt_q);
				end
				default: ;
			endcase
		end
	end

	// item payload and result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q  <= brfr_func_t'(func);
				wbyte_q <= write_byte;
				amt_q   <= amount;
			end
			ST_EVAL: begin
				addr_q <= rp_q;
				case (func_q)
					FN_WRITE: begin
						word_q <= '0;
						ok_q   <= wr_ok;
						done_q <= wr_ok ? 12'd1 : 12'd0;
					end
					FN_READ, FN_PEEK: begin
						word_q <= rd_ok ? 32'd0 : '1;
						ok_q   <= 1'b0;
						done_q <= '0;
					end
					default: begin
						word_q <= '0;
						ok_q   <= amt_q != 12'd0;
						done_q <= (amt_q != 12'd0) ? skip_ext[11:0] : 12'd0;
					end
				endcase
			end
			ST_FETCH: begin
				addr_q <= usum;
				lane_q <= k_q[1:0];
				if (pend_q) begin
					word_q[8*lane_q +: 8] <= mem_rdata;
				end
			end
			ST_DRAIN: begin
				word_q[8*lane_q +: 8] <= mem_rdata;
				ok_q                  <= 1'b1;
				done_q                <= amt_q;
			end
			default: ;
		endcase
	end

	assign busy          = state_q != ST_IDLE;
	assign valid         = state_q == ST_OUT;
	assign value         = word_q;
	assign ok            = ok_q;
	assign done_count    = done_q;
	assign stored_count  = cnt_ext[11:0];
	assign free_count    = free_ext[11:0];
	assign total_read    = cons_q;
	assign total_written = acc_q;
endmodule

@@ rtl/brfr_chk.sv @@
// Port-level checker for the byte ring FIFO reader, bound to the top level.
// Depends on byte_ring_fifo_le_reader_macros.svh.
`include "byte_ring_fifo_le_reader_macros.svh"

module brfr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        valid,
	input logic        ok,
	input logic [11:0] done_count
);
	`BRFR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`BRFR_ASSERT_NOW(a_valid_busy, valid, busy)
	`BRFR_ASSERT_NEXT(a_valid_single, valid, !valid && !busy)
	`BRFR_ASSERT_NOW(a_fail_no_count, valid && !ok, done_count == 12'd0)
endmodule

bind byte_ring_fifo_le_reader brfr_chk u_brfr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.valid      (valid),
	.ok         (ok),
	.done_count (done_count)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for byte_ring_fifo_le_reader: directed and random item streams with
// a built-in byte FIFO predictor and scoreboard. Depends on brfr_pkg and the RTL.
module tb_top;
	import brfr_pkg::*;

	localparam int unsigned FIFO_DEPTH = 4096;
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [31:0] value;
		logic        ok;
		logic [11:0] done_count;
		logic [11:0] stored_count;
		logic [11:0] free_count;
		logic [31:0] total_read;
		logic [31:0] total_written;
	} fifo_result_t;

	class brfr_scoreboard;
		logic [7:0]   mem [FIFO_DEPTH];
		int unsigned  rd_ptr;
		int unsigned  wr_ptr;
		logic [31:0]  consumed;
		logic [31:0]  accepted;
		fifo_result_t expected_q[$];
		int           errors;

		function new();
			rd_ptr   = 0;
			wr_ptr   = 0;
			consumed = '0;
			accepted = '0;
			errors   = 0;
		endfunction

		function int unsigned held();
			return (wr_ptr + FIFO_DEPTH - rd_ptr) % FIFO_DEPTH;
		endfunction

		function void note_item(brfr_func_t fn, logic [7:0] wb, logic [11:0] amt);
			fifo_result_t exp_r;
			int unsigned  stored;
			int unsigned  n;
			stored = held();
			exp_r  = '0;
			case (fn)
				FN_WRITE: begin
					if (stored < FIFO_DEPTH - 1) begin
						mem[PTR_W'(wr_ptr)] = wb;
						wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
						accepted++;
						exp_r.ok = 1'b1;
						exp_r.done_count = 12'd1;
					end
				end
				FN_READ, FN_PEEK: begin
					if (amt >= 1 && amt <= MAX_WORD_BYTES && amt <= stored) begin
						for (int k = 0; k < amt; k++)
							exp_r.value[8*k +: 8] = mem[PTR_W'((rd_ptr + k) % FIFO_DEPTH)];
						exp_r.ok = 1'b1;
						exp_r.done_count = amt;
						if (fn == FN_READ) begin
							rd_ptr = (rd_ptr + amt) % FIFO_DEPTH;
							consumed += amt;
						end
					end else begin
						exp_r.value = '1;
					end
				end
				default: begin
					if (amt != 0) begin
						n = (amt > stored) ? stored : amt;
						rd_ptr = (rd_ptr + n) % FIFO_DEPTH;
						consumed += n;
						exp_r.ok = 1'b1;
						exp_r.done_count = 12'(n);
					end
				end
			endcase
			stored = held();
			exp_r.stored_count  = 12'(stored);
			exp_r.free_count    = 12'(FIFO_DEPTH - 1 - stored);
			exp_r.total_read    = consumed;
			exp_r.total_written = accepted;
			expected_q.push_back(exp_r);
		endfunction

		function void cmp(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t MISMATCH %s expected 0x%0h actual 0x%0h",
					$time, field, want, got);
			end
		endfunction

		function void check_result(fifo_result_t got);
			fifo_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t MISMATCH unexpected result expected none actual 0x%0h",
					$time, got);
				return;
			end
			want = expected_q.pop_front();
			cmp("value", want.value, got.value);
			cmp("ok", 32'(want.ok), 32'(got.ok));
			cmp("done_count", 32'(want.done_count), 32'(got.done_count));
			cmp("stored_count", 32'(want.stored_count), 32'(got.stored_count));
			cmp("free_count", 32'(want.free_count), 32'(got.free_count));
			cmp("total_read", want.total_read, got.total_read);
			cmp("total_written", want.total_written, got.total_written);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [7:0]  write_byte;
	logic [11:0] amount;
	logic        valid;
	logic [31:0] value;
	logic        ok;
	logic [11:0] done_count;
	logic [11:0] stored_count;
	logic [11:0] free_count;
	logic [31:0] total_read;
	logic [31:0] total_written;

	brfr_scoreboard sb = new();
	fifo_result_t   seen_result;
	int unsigned    sender_idle;
	int unsigned    cycles;

	byte_ring_fifo_le_reader #(
		.DEPTH(FIFO_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.write_byte(write_byte),
		.amount(amount),
		.valid(valid),
		.value(value),
		.ok(ok),
		.done_count(done_count),
		.stored_count(stored_count),
		.free_count(free_count),
		.total_read(total_read),
		.total_written(total_written)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result first, so an item taken on the same edge never matches itself
	always @(posedge clk) begin
		if (arst_n) begin
			if (valid) begin
				seen_result = '{value, ok, done_count, stored_count, free_count,
					total_read, total_written};
				sb.check_result(seen_result);
			end
			if (start && !busy)
				sb.note_item(brfr_func_t'(func), write_byte, amount);
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input brfr_func_t fn, input logic [7:0] wb,
		input logic [11:0] amt);
		bit taken;
		while ($urandom_range(0, 99) < sender_idle) begin
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start      = 1'b1;
		func       = fn;
		write_byte = wb;
		amount     = amt;
		taken      = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random(input int unsigned n_items);
		int unsigned pick;
		logic [11:0] amt;
		for (int unsigned i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				send_item(FN_WRITE, 8'($urandom), 12'($urandom));
			end else if (pick < 85) begin
				pick = $urandom_range(0, 99);
				if (pick < 85)
					amt = 12'($urandom_range(1, MAX_WORD_BYTES));
				else if (pick < 93)
					amt = $urandom_range(0, 1) ? 12'd0 : 12'(MAX_WORD_BYTES + 1);
				else
					amt = 12'($urandom);
				send_item(($urandom_range(0, 1) != 0) ? FN_READ : FN_PEEK, 8'($urandom),
					amt);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					amt = 12'($urandom_range(1, 6));
				else if (pick < 80)
					amt = 12'd0;
				else
					amt = 12'($urandom);
				send_item(FN_SKIP, 8'($urandom), amt);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = FN_WRITE;
		write_byte  = '0;
		amount      = '0;
		sender_idle = 28;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty fifo corner cases, then writes followed by peeks, reads and skips
		send_item(FN_READ, 8'h00, 12'd1);
		send_item(FN_PEEK, 8'h00, 12'd4);
		send_item(FN_SKIP, 8'h00, 12'd0);
		send_item(FN_SKIP, 8'hFF, 12'hFFF);
		send_item(FN_READ, 8'h00, 12'd0);
		send_item(FN_WRITE, 8'h00, 12'hFFF);
		send_item(FN_WRITE, 8'hFF, 12'd0);
		send_item(FN_WRITE, 8'hA5, 12'd0);
		send_item(FN_WRITE, 8'h5A, 12'd0);
		send_item(FN_WRITE, 8'h01, 12'd0);
		send_item(FN_PEEK, 8'h00, 12'd5);
		send_item(FN_READ, 8'h00, 12'hFFF);
		send_item(FN_PEEK, 8'h00, 12'd1);
		send_item(FN_PEEK, 8'h00, 12'd2);
		send_item(FN_PEEK, 8'h00, 12'd3);
		send_item(FN_PEEK, 8'h00, 12'd4);
		send_item(FN_READ, 8'h00, 12'd4);
		send_item(FN_READ, 8'h00, 12'd2);
		send_item(FN_PEEK, 8'h00, 12'd2);
		send_item(FN_SKIP, 8'h00, 12'd3);
		send_item(FN_WRITE, 8'h80, 12'd0);
		send_item(FN_READ, 8'h00, 12'd1);
		wait_drained();

		run_random(400);
		wait_drained();

		sender_idle = 55;
		run_random(400);
		wait_drained();

		// fill to full, overflow, then force word accesses across the store end
		sender_idle = 0;
		send_item(FN_SKIP, 8'($urandom), 12'hFFF);
		while (sb.held() < FIFO_DEPTH - 1)
			send_item(FN_WRITE, 8'($urandom), 12'($urandom));
		repeat (3) send_item(FN_WRITE, 8'($urandom), 12'($urandom));
		send_item(FN_PEEK, 8'h00, 12'd4);
		if (sb.rd_ptr < FIFO_DEPTH - 3)
			send_item(FN_SKIP, 8'h00, 12'(FIFO_DEPTH - 3 - sb.rd_ptr));
		repeat (6) send_item(FN_WRITE, 8'($urandom), 12'($urandom));
		send_item(FN_PEEK, 8'h00, 12'd4);
		send_item(FN_READ, 8'h00, 12'd4);
		send_item(FN_PEEK, 8'h00, 12'd3);
		send_item(FN_READ, 8'h00, 12'd2);
		run_random(350);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/brfr_pkg.sv
rtl/brfr_wrap_add.sv
rtl/brfr_mem.sv
rtl/byte_ring_fifo_le_reader.sv
rtl/brfr_chk.sv
dv/tb_top.sv
